@@ design/sorted_list_table_top_macros.svh @@
// Assertion macros used by the sorted list table RTL.
`ifndef SORTED_LIST_TABLE_TOP_MACROS_SVH
`define SORTED_LIST_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list table: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list table: next-cycle check failed");
`else
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/slt_pkg.sv @@
// Types and constants for the sorted list table.
`timescale 1ns / 1ps
package slt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int COUNT_OUT_W   = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic                      valid;
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_OUT_W-1:0]    count;
    } t_result;

endpackage

@@ design/slt_mem.sv @@
// Value store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module slt_mem #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT,
    parameter int AW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [AW-1:0]                      i_wr_addr,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_wr_data,
    input  logic [AW-1:0]                      i_rd_addr,
    output logic signed [slt_pkg::VALUE_W-1:0] o_rd_data
);
    import slt_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/slt_ctrl.sv @@
// Sequencer: scans the store, shifts entries and forms the result beat.
`timescale 1ns / 1ps
`include "sorted_list_table_top_macros.svh"
module slt_ctrl #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [slt_pkg::OP_W-1:0]           i_op,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    output logic                               o_busy,
    output logic [AW-1:0]                      o_rd_addr,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_rd_data,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output logic signed [slt_pkg::VALUE_W-1:0] o_wr_data,
    output slt_pkg::t_result                   o_res
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_WRV,
        S_SRCH,
        S_SHF
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic                      r_lookup, n_lookup;
    t_result                   r_res, n_res;

    logic accept;
    logic last;
    logic is_less;
    logic is_eq;
    logic is_gt;

    assign accept  = i_start && (r_state == S_IDLE);
    assign last    = (r_idx == r_count - 1'b1);
    assign is_less = (i_rd_data < r_val);
    assign is_eq   = (i_rd_data == r_val);
    assign is_gt   = (i_rd_data > r_val);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_val        = r_val;
        n_lookup     = r_lookup;
        n_res.valid  = 1'b0;
        n_res.status = ST_OK;
        n_res.value  = r_val;
        o_rd_addr    = AW'(r_idx + 1'b1);
        o_wr_en      = 1'b0;
        o_wr_addr    = AW'(r_idx + 1'b1);
        o_wr_data    = r_val;

        case (r_state)
            S_IDLE: begin
                o_rd_addr = (i_op == OP_INSERT) ? AW'(r_count - 1'b1) : '0;
                if (accept) begin
                    n_val       = i_value;
                    n_lookup    = i_op[1];
                    n_res.value = i_value;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.valid  = 1'b1;
                            n_res.status = ST_FULL;
                        end else if (r_count == '0) begin
                            o_wr_en     = 1'b1;
                            o_wr_addr   = '0;
                            o_wr_data   = i_value;
                            n_count     = r_count + 1'b1;
                            n_res.valid = 1'b1;
                        end else begin
                            n_idx   = r_count - 1'b1;
                            n_state = S_INS;
                        end
                    end else if (r_count == '0) begin
                        n_res.valid  = 1'b1;
                        n_res.status = ST_EMPTY;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SRCH;
                    end
                end
            end
            S_INS: begin
                // walk down from the top, moving each entry not below the value up by one
                o_rd_addr = AW'(r_idx - 1'b1);
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx + 1'b1);
                if (!is_less) begin
                    o_wr_data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_WRV;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    o_wr_data   = r_val;
                    n_count     = r_count + 1'b1;
                    n_res.valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WRV: begin
                o_wr_en     = 1'b1;
                o_wr_addr   = '0;
                o_wr_data   = r_val;
                n_count     = r_count + 1'b1;
                n_res.valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SRCH: begin
                if (is_eq) begin
                    if (r_lookup) begin
                        n_res.valid = 1'b1;
                        n_state     = S_IDLE;
                    end else if (last) begin
                        n_count     = r_count - 1'b1;
                        n_res.valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SHF;
                    end
                end else if (is_gt || last) begin
                    n_res.valid  = 1'b1;
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHF: begin
                // close the gap: each entry above the removed one drops by one
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx - 1'b1);
                o_wr_data = i_rd_data;
                if (last) begin
                    n_count     = r_count - 1'b1;
                    n_res.valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.count = COUNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res.valid <= n_res.valid;
        end
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_lookup     <= n_lookup;
        r_res.status <= n_res.status;
        r_res.value  <= n_res.value;
        r_res.count  <= n_res.count;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

    `SLT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SLT_ASSERT_IMP(a_count_with_beat, i_clk, i_rst_n, r_count != $past(r_count), r_res.valid)
    `SLT_ASSERT_NXT(a_full_reject, i_clk, i_rst_n, accept && (i_op == OP_INSERT) && (r_count == CW'(DEPTH)), r_res.valid && (r_res.status == ST_FULL) && (r_count == $past(r_count)))
    `SLT_ASSERT_IMP(a_write_in_range, i_clk, i_rst_n, o_wr_en, CW'(o_wr_addr) <= r_count)
    `SLT_ASSERT_NXT(a_empty_reply, i_clk, i_rst_n, accept && (i_op != OP_INSERT) && (r_count == '0), r_res.valid && (r_res.status == ST_EMPTY))

endmodule

@@ design/sorted_list_table_top.sv @@
// Top level of the sorted list table: sequencer plus value store.
`timescale 1ns / 1ps
// An insert into an empty or full table and a remove or lookup on an empty one are answered
// straight from idle, without raising busy; otherwise an insert walks down from the top entry,
// a lookup or remove walks up from the bottom, and a hit remove then shifts the entries above
// it down. One store entry is visited per cycle.
// Throughput: one item at a time; busy drops in the beat cycle, so the next item may be taken
// at the edge that takes the beat. The receiver cannot stall. Synchronous active-low reset.
module sorted_list_table_top #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [slt_pkg::OP_W-1:0]           i_op,
    input  logic signed [slt_pkg::VALUE_W-1:0] i_value,
    output logic                               busy,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic signed [slt_pkg::VALUE_W-1:0] o_value_out,
    output logic [slt_pkg::COUNT_OUT_W-1:0]    o_count
);
    import slt_pkg::*;

    // Address width for the store, count width able to hold DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    t_result                   res;

    // Sequencer: decodes the op, walks the store one entry a cycle and builds the beat.
    // Reads always run ahead of (insert: below, remove: above) the entry being written,
    // so the store never sees a read and a write of the same entry in one cycle.
    slt_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_busy    (busy),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_res     (res)
    );

    // Value store: data read above the count is never used, so no reset is needed.
    slt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result beat: held one cycle only, straight from the sequencer's output register.
    assign o_valid     = res.valid;
    assign o_status    = res.status;
    assign o_value_out = res.value;
    assign o_count     = res.count;

endmodule
